// File: hw/rtl/assert_macros.svh
// Assertion macros used by the parser core RTL.
// No dependencies; every macro clocks on aclk and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Signal must be low whenever the condition holds.
`define ASSERT_NEVER(label, cond, sig, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> !(sig)) else $error(msg);

`endif

// File: hw/rtl/nrmc_pkg.sv
// Package for the RMC position parser: character codes, field positions,
// accumulator widths and arithmetic helpers. No dependencies.
package nrmc_pkg;

    localparam int FRACTION_DIGITS_DEF = 4;

    localparam int LAT_W   = 27;   // latitude magnitude
    localparam int LON_W   = 28;   // longitude magnitude
    localparam int LATS_W  = 28;   // signed latitude
    localparam int LONS_W  = 29;   // signed longitude
    localparam int POW10_W = 20;   // holds 10^6

    localparam logic [LAT_W-1:0] LAT_MAX = '1;
    localparam logic [LON_W-1:0] LON_MAX = '1;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_E      = 8'h45;

    typedef logic [3:0] field_num_t;

    localparam field_num_t FLD_STATUS = 4'd1;
    localparam field_num_t FLD_LAT    = 4'd2;
    localparam field_num_t FLD_NS     = 4'd3;
    localparam field_num_t FLD_LON    = 4'd4;
    localparam field_num_t FLD_EW     = 4'd5;
    localparam field_num_t FLD_LAST   = 4'd15;

    localparam logic [2:0] HDR_LAST = 3'd6;   // index of the closing ','

    // "$GPRMC," one character per index
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h24;   // $
            3'd1:    ch = 8'h47;   // G
            3'd2:    ch = 8'h50;   // P
            3'd3:    ch = 8'h52;   // R
            3'd4:    ch = 8'h4D;   // M
            3'd5:    ch = 8'h43;   // C
            3'd6:    ch = CH_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [POW10_W-1:0] pow10(input logic [2:0] k);
        logic [POW10_W-1:0] p;
        case (k)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

    // acc*10 + d, clipped at maxv
    function automatic logic [LON_W-1:0] sat_digit(input logic [LON_W-1:0] acc,
                                                   input logic [3:0]       d,
                                                   input logic [LON_W-1:0] maxv);
        logic [LON_W+3:0] ext;
        logic [LON_W+3:0] v;
        ext = {4'd0, acc};
        v   = (ext << 3) + (ext << 1) + {{LON_W{1'b0}}, d};
        return (v > {4'd0, maxv}) ? maxv : v[LON_W-1:0];
    endfunction

    // zero-pad k missing fraction digits, clipped at maxv
    function automatic logic [LON_W-1:0] pad_frac(input logic [LON_W-1:0] acc,
                                                  input logic [2:0]       k,
                                                  input logic [LON_W-1:0] maxv);
        logic [LON_W+POW10_W-1:0] p;
        p = acc * pow10(k);
        return (p > {{POW10_W{1'b0}}, maxv}) ? maxv : p[LON_W-1:0];
    endfunction

endpackage

// File: hw/rtl/nmea_rmc_position_parser_core.sv
// RMC sentence position parser: byte stream in, one position beat per sentence.
// Depends on nrmc_pkg and assert_macros.svh.
//
//  channel | ports                                    | dir | beat
//  --------+------------------------------------------+-----+------------------------
//  input   | s_valid s_ready s_rx_byte[7:0]           | in  | one received byte
//  result  | m_valid m_ready m_fix_valid m_latitude   | out | one per '*' in sentence
//          | [27:0] m_longitude[28:0]                 |     |
//
// One byte per cycle sustained while no result waits. A byte is first held in the input
// register, then the parser state and (for '*') the result register update from it.
// The input register can still take one byte while a result waits; once it holds
// that byte, s_ready drops until m_ready frees the result.
// aresetn (synchronous, active low) clears parser state, stored position and
// both valid flags.
`include "assert_macros.svh"

module nmea_rmc_position_parser_core
    import nrmc_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF   // 1..6
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_fix_valid,
    output logic signed [LATS_W-1:0] m_latitude,
    output logic signed [LONS_W-1:0] m_longitude
);

    localparam int FRAC_W = $clog2(FRACTION_DIGITS + 1);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // result register
    logic                     m_valid_reg;
    logic                     m_fix_reg;
    logic signed [LATS_W-1:0] m_lat_reg;
    logic signed [LONS_W-1:0] m_lon_reg;

    // parser state
    logic [2:0]        hdr_cnt_reg,    hdr_cnt_next;
    logic              in_sent_reg,    in_sent_next;
    field_num_t        field_reg,      field_next;
    logic [1:0]        stat_len_reg,   stat_len_next;
    logic              stat_a_reg,     stat_a_next;
    logic [LAT_W-1:0]  lat_acc_reg,    lat_acc_next;
    logic [LON_W-1:0]  lon_acc_reg,    lon_acc_next;
    logic              point_reg,      point_next;
    logic [FRAC_W-1:0] frac_cnt_reg,   frac_cnt_next;
    logic              north_reg,      north_next;
    logic              east_reg,       east_next;
    logic [LATS_W-1:0] cur_lat_reg,    cur_lat_next;
    logic [LONS_W-1:0] cur_lon_reg,    cur_lon_next;

    logic              adv;
    logic              emit;
    logic              fix;
    logic [7:0]        c;
    logic              first;
    logic              is_digit;
    logic              take_digit;
    logic [2:0]        pad_k;
    logic              stat_end;
    logic [LAT_W-1:0]  lat_end;
    logic [LON_W-1:0]  lon_end;
    logic [LAT_W-1:0]  lat_fin;
    logic [LON_W-1:0]  lon_fin;
    logic [LON_W-1:0]  lat_step;
    logic [LON_W-1:0]  lon_step;

    // byte moves on when the result slot is free or being drained
    assign adv     = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    assign c          = in_byte_reg;
    assign first      = (stat_len_reg == 2'd0);
    assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign take_digit = !point_reg || (frac_cnt_reg < FRAC_W'(FRACTION_DIGITS));

    // field-end values: status exactly "A", fractions padded
    assign pad_k    = 3'(FRACTION_DIGITS) - 3'(frac_cnt_reg);
    assign stat_end = stat_a_reg && (stat_len_reg == 2'd1);
    assign lat_end  = LAT_W'(pad_frac({{(LON_W-LAT_W){1'b0}}, lat_acc_reg}, pad_k,
                                      {{(LON_W-LAT_W){1'b0}}, LAT_MAX}));
    assign lon_end  = pad_frac(lon_acc_reg, pad_k, LON_MAX);

    assign lat_fin  = (field_reg == FLD_LAT) ? lat_end : lat_acc_reg;
    assign lon_fin  = (field_reg == FLD_LON) ? lon_end : lon_acc_reg;

    // digit accumulate for the numeric fields
    assign lat_step = sat_digit({{(LON_W-LAT_W){1'b0}}, lat_acc_reg}, c[3:0],
                                {{(LON_W-LAT_W){1'b0}}, LAT_MAX});
    assign lon_step = sat_digit(lon_acc_reg, c[3:0], LON_MAX);

    always_comb begin
        hdr_cnt_next  = hdr_cnt_reg;
        in_sent_next  = in_sent_reg;
        field_next    = field_reg;
        stat_len_next = stat_len_reg;
        stat_a_next   = stat_a_reg;
        lat_acc_next  = lat_acc_reg;
        lon_acc_next  = lon_acc_reg;
        point_next    = point_reg;
        frac_cnt_next = frac_cnt_reg;
        north_next    = north_reg;
        east_next     = east_reg;
        cur_lat_next  = cur_lat_reg;
        cur_lon_next  = cur_lon_reg;
        emit          = 1'b0;
        fix           = 1'b0;

        if (adv) begin
            if (!in_sent_reg) begin
                // header hunt; a mismatching byte is dropped and matching restarts
                if (c == hdr_char(hdr_cnt_reg)) begin
                    if (hdr_cnt_reg == HDR_LAST) begin
                        hdr_cnt_next = 3'd0;
                        in_sent_next = 1'b1;
                    end else begin
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    end
                end else begin
                    hdr_cnt_next = 3'd0;
                end
            end else if (c == CH_STAR) begin
                // sentence end: close the open field, report
                fix  = (field_reg >= FLD_STATUS) &&
                       ((field_reg == FLD_STATUS) ? stat_end : stat_a_reg);
                emit = 1'b1;
                if (fix) begin
                    cur_lat_next = north_reg ? {1'b0, lat_fin} : -{1'b0, lat_fin};
                    cur_lon_next = east_reg  ? {1'b0, lon_fin} : -{1'b0, lon_fin};
                end
                in_sent_next = 1'b0;
                hdr_cnt_next = 3'd0;
            end else if (c == CH_COMMA) begin
                case (field_reg)
                    FLD_STATUS: stat_a_next  = stat_end;
                    FLD_LAT:    lat_acc_next = lat_end;
                    FLD_LON:    lon_acc_next = lon_end;
                    default:    ;
                endcase
                if (field_reg != FLD_LAST) begin
                    field_next = field_reg + 4'd1;
                end
                stat_len_next = 2'd0;
                point_next    = 1'b0;
                frac_cnt_next = '0;
            end else begin
                if (stat_len_reg != 2'd3) begin
                    stat_len_next = stat_len_reg + 2'd1;
                end
                case (field_reg)
                    FLD_STATUS: begin
                        if (first) begin
                            stat_a_next = (c == CH_A);
                        end
                    end
                    FLD_LAT: begin
                        if (c == CH_POINT) begin
                            point_next = 1'b1;
                        end else if (is_digit && take_digit) begin
                            lat_acc_next = lat_step[LAT_W-1:0];
                            if (point_reg) begin
                                frac_cnt_next = frac_cnt_reg + FRAC_W'(1);
                            end
                        end
                    end
                    FLD_NS:  north_next = first && (c == CH_N);
                    FLD_LON: begin
                        if (c == CH_POINT) begin
                            point_next = 1'b1;
                        end else if (is_digit && take_digit) begin
                            lon_acc_next = lon_step;
                            if (point_reg) begin
                                frac_cnt_next = frac_cnt_reg + FRAC_W'(1);
                            end
                        end
                    end
                    FLD_EW:  east_next = first && (c == CH_E);
                    default: ;
                endcase
            end

            // fresh field state at sentence start and after the sentence end
            if ((!in_sent_reg && in_sent_next) || emit) begin
                field_next    = '0;
                stat_len_next = 2'd0;
                stat_a_next   = 1'b0;
                lat_acc_next  = '0;
                lon_acc_next  = '0;
                point_next    = 1'b0;
                frac_cnt_next = '0;
                north_next    = 1'b0;
                east_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            hdr_cnt_reg  <= '0;
            in_sent_reg  <= 1'b0;
            field_reg    <= '0;
            stat_len_reg <= '0;
            stat_a_reg   <= 1'b0;
            lat_acc_reg  <= '0;
            lon_acc_reg  <= '0;
            point_reg    <= 1'b0;
            frac_cnt_reg <= '0;
            north_reg    <= 1'b0;
            east_reg     <= 1'b0;
            cur_lat_reg  <= '0;
            cur_lon_reg  <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            hdr_cnt_reg  <= hdr_cnt_next;
            in_sent_reg  <= in_sent_next;
            field_reg    <= field_next;
            stat_len_reg <= stat_len_next;
            stat_a_reg   <= stat_a_next;
            lat_acc_reg  <= lat_acc_next;
            lon_acc_reg  <= lon_acc_next;
            point_reg    <= point_next;
            frac_cnt_reg <= frac_cnt_next;
            north_reg    <= north_next;
            east_reg     <= east_next;
            cur_lat_reg  <= cur_lat_next;
            cur_lon_reg  <= cur_lon_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (emit) begin
            m_fix_reg <= fix;
            m_lat_reg <= cur_lat_next;
            m_lon_reg <= cur_lon_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_fix_valid = m_fix_reg;
    assign m_latitude  = m_lat_reg;
    assign m_longitude = m_lon_reg;

    // header counter is parked at zero for the whole sentence
    `ASSERT_NEVER(a_hdr_idle, in_sent_reg, (hdr_cnt_reg != 3'd0), "header count moved in sentence")
    // a '*' inside a sentence always leaves a result beat behind
    `ASSERT_CLK(a_star_emits, (adv && in_sent_reg && (in_byte_reg == CH_STAR)) |=> m_valid, "sentence end without result")
    // a pending result always shows the stored position
    `ASSERT_CLK(a_out_pos, m_valid |-> ((m_lat_reg == cur_lat_reg) && (m_lon_reg == cur_lon_reg)), "result differs from stored position")
    // fraction counter never runs past the configured digit count
    `ASSERT_CLK(a_frac_cap, 1'b1 |-> (frac_cnt_reg <= FRAC_W'(FRACTION_DIGITS)), "fraction count overrun")

endmodule
